// ----- hdl/ppspp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppspp_pkg
// Shared codes, constants and beat types for the SPP register core.
// ----------------------------------------------------------------------------
package ppspp_pkg;

  // command codes
  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;

  // register indexes
  localparam logic [1:0] REG_DATA    = 2'd0;
  localparam logic [1:0] REG_STATUS  = 2'd1;
  localparam logic [1:0] REG_CONTROL = 2'd2;
  localparam logic [1:0] REG_INVALID = 2'd3;

  localparam logic [7:0] STATUS_RESET   = 8'hdf;  // no printer attached
  localparam logic [2:0] CTRL_READ_ONES = 3'b111;
  localparam int unsigned CTRL_IRQ_EN_BIT = 4;
  localparam int unsigned STATUS_ACK_BIT  = 6;

  typedef struct packed {
    logic [1:0] command;
    logic [1:0] register_number;
    logic [7:0] value;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       error;
    logic       irq_level;
    logic       output_strobe;
    logic [7:0] pin_data;
    logic [4:0] pin_control;
  } rsp_t;

endpackage

// ----- hdl/ppspp_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppspp_in_stage
// Input register: holds one request beat until the register file takes it.
// ----------------------------------------------------------------------------
module ppspp_in_stage import ppspp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_req,
  output logic req_valid,
  output req_t req,
  input  logic req_take
);

  logic valid_r, valid_nxt;
  req_t req_r;

  assign in_ready  = !valid_r || req_take;
  assign req_valid = valid_r;
  assign req       = req_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r <= in_req;
    end
  end

endmodule

// ----- hdl/ppspp_regfile.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppspp_regfile
// Data, status and control registers, ack edge detect and interrupt flag.
// Decodes one request and commits the state change when it is taken.
// ----------------------------------------------------------------------------
module ppspp_regfile import ppspp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  req_t req,
  input  logic commit,
  output rsp_t rsp
);

  logic [7:0] data_r, data_nxt;
  logic [7:0] status_r, status_nxt;
  logic [4:0] ctrl_r, ctrl_nxt;
  logic       irq_r, irq_nxt;
  logic       bad_idx;
  logic       old_ack, new_ack;

  assign bad_idx = (req.register_number == REG_INVALID);
  assign old_ack = status_r[STATUS_ACK_BIT];
  assign new_ack = req.value[STATUS_ACK_BIT];

  always_comb begin
    data_nxt          = data_r;
    status_nxt        = status_r;
    ctrl_nxt          = ctrl_r;
    irq_nxt           = irq_r;
    rsp.read_data     = 8'd0;
    rsp.error         = 1'b0;
    rsp.output_strobe = 1'b0;
    unique case (req.command)
      CMD_READ: begin
        if (bad_idx) begin
          rsp.error = 1'b1;
        end else if (req.register_number == REG_DATA) begin
          rsp.read_data = data_r;
        end else if (req.register_number == REG_STATUS) begin
          rsp.read_data = status_r;
        end else begin
          rsp.read_data = {CTRL_READ_ONES, ctrl_r};
        end
      end
      CMD_WRITE: begin
        if (bad_idx) begin
          rsp.error = 1'b1;
        end else begin
          if (req.register_number == REG_DATA) begin
            data_nxt = req.value;
          end else if (req.register_number == REG_CONTROL) begin
            // direction bit and above are dropped
            ctrl_nxt = req.value[4:0];
            if (!req.value[CTRL_IRQ_EN_BIT]) begin
              irq_nxt = 1'b0;
            end
          end
          rsp.output_strobe = 1'b1;
        end
      end
      CMD_STATUS: begin
        status_nxt = req.value;
        if (old_ack && !new_ack && ctrl_r[CTRL_IRQ_EN_BIT]) begin
          irq_nxt = 1'b1;
        end else if (!old_ack && new_ack) begin
          irq_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
    rsp.irq_level   = irq_nxt;
    rsp.pin_data    = data_nxt;
    rsp.pin_control = ctrl_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r   <= 8'd0;
      status_r <= STATUS_RESET;
      ctrl_r   <= 5'd0;
      irq_r    <= 1'b0;
    end else if (commit) begin
      data_r   <= data_nxt;
      status_r <= status_nxt;
      ctrl_r   <= ctrl_nxt;
      irq_r    <= irq_nxt;
    end
  end

endmodule

// ----- hdl/ppspp_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppspp_out_stage
// Result register: holds one response beat until the sink takes it.
// ----------------------------------------------------------------------------
module ppspp_out_stage import ppspp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic load_valid,
  output logic load_ready,
  input  rsp_t load_rsp,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_rsp
);

  logic valid_r, valid_nxt;
  rsp_t rsp_r;

  assign load_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_rsp    = rsp_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load_ready) begin
      valid_nxt = load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      rsp_r <= load_rsp;
    end
  end

endmodule

// ----- hdl/parallel_port_spp_registers_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallel_port_spp_registers_core
// SPP-mode parallel port register file with acknowledge interrupt.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake            | Payload
// in_     | input     | in_valid / in_ready   | command, register_number, value
// out_    | output    | out_valid / out_ready | read_data, error, irq_level,
//         |           |                       | output_strobe, pin_data, pin_control
//
// One beat per cycle sustained while the sink is ready; an accepted input beat
// passes through the input register, then decode and state update into the
// result register, where out_valid rises and the result can be taken.
// Register state commits as a request moves into the result register.
// Synchronous active-low reset clears valids, status reads back 0xdf.
// A stalled sink holds the result register; one more beat waits in the input
// register before in_ready drops.
// ----------------------------------------------------------------------------
module parallel_port_spp_registers_core import ppspp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [1:0] in_register_number,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_error,
  output logic       out_irq_level,
  output logic       out_output_strobe,
  output logic [7:0] out_pin_data,
  output logic [4:0] out_pin_control
);

  req_t in_req, req;
  rsp_t rsp, out_rsp;
  logic req_valid, load_ready, commit;

  assign in_req.command         = in_command;
  assign in_req.register_number = in_register_number;
  assign in_req.value           = in_value;

  assign commit = req_valid && load_ready;

  ppspp_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_req    (in_req),
    .req_valid (req_valid),
    .req       (req),
    .req_take  (commit)
  );

  ppspp_regfile u_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (req),
    .commit (commit),
    .rsp    (rsp)
  );

  ppspp_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (req_valid),
    .load_ready (load_ready),
    .load_rsp   (rsp),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_rsp    (out_rsp)
  );

  assign out_read_data     = out_rsp.read_data;
  assign out_error         = out_rsp.error;
  assign out_irq_level     = out_rsp.irq_level;
  assign out_output_strobe = out_rsp.output_strobe;
  assign out_pin_data      = out_rsp.pin_data;
  assign out_pin_control   = out_rsp.pin_control;

endmodule
